### sv/hlc_pkg.sv
// Shared types and constants for the hybrid logical clock stamp unit.
// No dependencies; imported by every module of the block.
package hlc_pkg;

  localparam int unsigned StampW         = 64;
  localparam int unsigned NsecW          = 60;
  localparam int unsigned UnitsShift     = 4;   // 16 stamp units per nanosecond
  localparam int unsigned LogicalBitsDef = 18;
  localparam logic [63:0] EpsilonReset   = 64'd16000000000;

  // Operation codes carried in the input tuser.
  typedef enum logic {
    OP_LOCAL   = 1'b0,
    OP_RECEIVE = 1'b1
  } hlc_op_e;

  // Result of one update, together with the clock value that follows it.
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [StampW-1:0] lead_offset;
    logic              sync_error;
    logic [StampW-1:0] next_clock;
  } hlc_upd_t;

endpackage

### sv/hlc_cfg.sv
// Epsilon limit register of the hybrid logical clock unit.
// Depends on hlc_pkg; written values are rounded up to a whole physical tick.
module hlc_cfg #(
  parameter int unsigned LOGICAL_BITS = hlc_pkg::LogicalBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hlc_pkg::StampW-1:0] cfg_wdata_i,
  output logic [hlc_pkg::StampW-1:0] epsilon_o
);
  import hlc_pkg::*;

  localparam logic [StampW-1:0] LogicMask = (64'd1 << LOGICAL_BITS) - 64'd1;

  logic [StampW-1:0] eps_q, eps_d;

  // Round up, wrapping at the top of the range.
  assign eps_d = (cfg_wdata_i + LogicMask) & ~LogicMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsilonReset;
    end else if (cfg_we_i) begin
      eps_q <= eps_d;
    end
  end

  assign epsilon_o = eps_q;

  a_eps_rounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (eps_q & LogicMask) == '0)
    else $error("epsilon limit not a whole physical tick after a write");

endmodule

### sv/hlc_update.sv
// Combinational stamp update: local event advance and message receive merge.
// Depends on hlc_pkg for the operation codes and the result structure.
module hlc_update #(
  parameter int unsigned LOGICAL_BITS = hlc_pkg::LogicalBitsDef
) (
  input  hlc_pkg::hlc_op_e            op_i,
  input  logic [hlc_pkg::NsecW-1:0]   phys_nsec_i,
  input  logic [hlc_pkg::StampW-1:0]  msg_stamp_i,
  input  logic [hlc_pkg::StampW-1:0]  clock_i,
  input  logic [hlc_pkg::StampW-1:0]  epsilon_i,
  output hlc_pkg::hlc_upd_t           upd_o
);
  import hlc_pkg::*;

  localparam logic [StampW-1:0] PhysMask = ~((64'd1 << LOGICAL_BITS) - 64'd1);

  logic [StampW-1:0] pt, hp, ml, clk_inc, msg_inc, max_inc, off, local_nx, merge_nx;
  logic              err;

  // Scaling by 16 is a shift; the 60-bit nanosecond value times 16 fills the 64-bit stamp exactly.
  assign pt      = {phys_nsec_i, {UnitsShift{1'b0}}} & PhysMask;
  assign hp      = clock_i & PhysMask;
  assign ml      = msg_stamp_i & PhysMask;
  assign clk_inc = clock_i + 64'd1;
  assign msg_inc = msg_stamp_i + 64'd1;
  assign max_inc = (clock_i < msg_stamp_i) ? msg_inc : clk_inc;
  assign off     = (ml > pt) ? (ml - pt) : '0;

  assign local_nx = (hp < pt) ? pt : clk_inc;

  always_comb begin
    if (hp < ml) begin
      merge_nx = (ml < pt) ? pt : msg_inc;
    end else if (hp < pt) begin
      merge_nx = pt;
    end else if (pt <= ml) begin
      merge_nx = max_inc;
    end else begin
      merge_nx = clk_inc;
    end
  end

  always_comb begin
    upd_o = '0;
    err   = 1'b0;
    case (op_i)
      OP_LOCAL: begin
        upd_o.stamp      = local_nx;
        upd_o.next_clock = local_nx;
      end
      OP_RECEIVE: begin
        err               = off > epsilon_i;
        upd_o.lead_offset = off;
        upd_o.sync_error  = err;
        upd_o.stamp       = err ? '0 : merge_nx;
        upd_o.next_clock  = err ? clock_i : merge_nx;
      end
      default: begin
        upd_o.next_clock = clock_i;
      end
    endcase
  end

endmodule

### sv/hybrid_logical_clock_top.sv
// Hybrid logical clock stamp unit: input register, update logic, result register.
// An accepted input word passes through the input register and the result register to the master side.
// Throughput is one word per cycle while the master side accepts; the clock register is updated as each result loads.
// Reset clears the clock stamp to zero, empties both stages and loads the epsilon reset value.
// Depends on hlc_pkg, hlc_cfg and hlc_update.
module hybrid_logical_clock_top #(
  parameter int unsigned LOGICAL_BITS = hlc_pkg::LogicalBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,      // epsilon_limit
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,     // phys_nsec[59:0], msg_stamp[123:60], zero pad
  input  logic         s_axis_tuser,     // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,     // stamp[63:0], lead_offset[127:64]
  output logic         m_axis_tuser      // sync_error
);
  import hlc_pkg::*;

  logic              in_vld_q, out_vld_q;
  hlc_op_e           in_op_q;
  logic [NsecW-1:0]  in_nsec_q;
  logic [StampW-1:0] in_msg_q;
  logic [StampW-1:0] clock_q, epsilon;
  logic [StampW-1:0] out_stamp_q, out_lead_q;
  logic              out_err_q;
  logic              in_load, out_load, out_free;
  hlc_upd_t          upd;

  hlc_cfg #(.LOGICAL_BITS(LOGICAL_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .epsilon_o   (epsilon)
  );

  hlc_update #(.LOGICAL_BITS(LOGICAL_BITS)) u_update (
    .op_i        (in_op_q),
    .phys_nsec_i (in_nsec_q),
    .msg_stamp_i (in_msg_q),
    .clock_i     (clock_q),
    .epsilon_i   (epsilon),
    .upd_o       (upd)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign out_load      = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      clock_q   <= '0;
    end else begin
      if (in_load) begin
        in_vld_q <= 1'b1;
      end else if (out_load) begin
        in_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
        clock_q   <= upd.next_clock;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_op_q   <= hlc_op_e'(s_axis_tuser);
      in_nsec_q <= s_axis_tdata[NsecW-1:0];
      in_msg_q  <= s_axis_tdata[NsecW+StampW-1:NsecW];
    end
    if (out_load) begin
      out_stamp_q <= upd.stamp;
      out_lead_q  <= upd.lead_offset;
      out_err_q   <= upd.sync_error;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_lead_q, out_stamp_q};
  assign m_axis_tuser  = out_err_q;

  a_err_zero_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:0] == '0))
    else $error("sync error word carries a non-zero stamp");

  a_err_keeps_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && upd.sync_error) |=> $stable(clock_q))
    else $error("clock moved on a rejected message");

  a_local_no_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && in_op_q == OP_LOCAL) |=> (out_lead_q == '0 && !out_err_q))
    else $error("local event produced a lead or a sync error");

  a_stamp_is_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !upd.sync_error) |=> (out_stamp_q == clock_q))
    else $error("result stamp differs from the stored clock");

endmodule

### sim/hybrid_logical_clock_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for hybrid_logical_clock_top: directed table followed by random phases.
// Results are checked against an in-bench model of the stamp update; depends on hlc_pkg and the RTL.
module hybrid_logical_clock_top_test;
  import hlc_pkg::*;

  localparam logic [63:0] LogicMask  = (64'd1 << LogicalBitsDef) - 64'd1;
  localparam logic [63:0] PhysMask   = ~LogicMask;
  localparam logic [63:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TopPhys    = 64'hFFFF_FFFF_FFFC_0000;
  localparam logic [59:0] NsecMax    = 60'hFFF_FFFF_FFFF_FFFF;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseWords = 131;

  typedef struct packed {
    logic [63:0] stamp;
    logic [63:0] lead;
    logic        sync_err;
  } stamp_result_t;

  typedef struct packed {
    logic        is_cfg;
    hlc_op_e     op;
    logic [59:0] nsec;
    logic [63:0] arg;      // message stamp, or the epsilon value on a register row
    logic        typed;
    logic [63:0] w_stamp;
    logic [63:0] w_lead;
    logic        w_err;
  } step_row_t;

  // Rows with typed = 1 carry a hand-worked result; the others use the model below.
  localparam int unsigned NumRows = 24;
  localparam step_row_t DirRows [NumRows] = '{
    '{1'b0, OP_LOCAL,   60'd0,       64'd0,          1'b1, 64'd1,   64'd0,       1'b0},
    '{1'b0, OP_LOCAL,   60'd0,       64'd0,          1'b1, 64'd2,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, 60'd0,       AllOnes,        1'b1, 64'd0,   TopPhys,     1'b1},
    '{1'b0, OP_RECEIVE, 60'd0,       64'h3_FFFF,     1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_LOCAL,   60'd1000,    64'd0,          1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_LOCAL,   NsecMax,     AllOnes,        1'b1, TopPhys, 64'd0,       1'b0},
    '{1'b0, OP_LOCAL,   NsecMax,     64'd0,          1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, NsecMax,     AllOnes,        1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_LOCAL,   60'd0,       64'd0,          1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b1, OP_LOCAL,   60'd0,       64'd1,          1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, 60'd0,       64'h4_0000,     1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, 60'd0,       64'h8_0000,     1'b1, 64'd0,   64'h8_0000,  1'b1},
    '{1'b0, OP_RECEIVE, 60'h1_0000,  64'hC_0000,     1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, 60'h1_0000,  64'h13_FFFF,    1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_LOCAL,   60'h1_0000,  64'd0,          1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, 60'h2_0000,  64'h4_0000,     1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, 60'h1_0000,  64'd0,          1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b1, OP_LOCAL,   60'd0,       AllOnes,        1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, 60'd0,       64'h4_0000,     1'b1, 64'd0,   64'h4_0000,  1'b1},
    '{1'b0, OP_RECEIVE, 60'h1_0000,  64'h10_0000,    1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b1, OP_LOCAL,   60'd0,       TopPhys,        1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_RECEIVE, 60'd0,       AllOnes,        1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b1, OP_LOCAL,   60'd0,       EpsilonReset,   1'b0, 64'd0,   64'd0,       1'b0},
    '{1'b0, OP_LOCAL,   60'd12345,   AllOnes,        1'b0, 64'd0,   64'd0,       1'b0}
  };

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [63:0]  cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  logic [63:0]   hlc_now;
  logic [63:0]   epsilon_now;
  stamp_result_t pending_stamps_q[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   src_idle_pct   = 16;
  int unsigned   snk_idle_pct   = 16;

  hybrid_logical_clock_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Moves the clock stamp on by one event and returns the word the block should emit.
  function automatic stamp_result_t advance_clock(hlc_op_e op, logic [59:0] nsec,
                                                  logic [63:0] msg);
    stamp_result_t res;
    logic [63:0]   pt;
    logic [63:0]   hp;
    logic [63:0]   ml;
    logic [63:0]   nxt;
    pt  = ({4'b0, nsec} << UnitsShift) & PhysMask;
    hp  = hlc_now & PhysMask;
    ml  = msg & PhysMask;
    res = '0;
    if (op == OP_LOCAL) begin
      nxt       = (hp < pt) ? pt : hlc_now + 64'd1;
      hlc_now   = nxt;
      res.stamp = nxt;
    end else begin
      res.lead = (ml > pt) ? ml - pt : 64'd0;
      if (res.lead > epsilon_now) begin
        res.sync_err = 1'b1;
      end else begin
        if (hp < ml) begin
          nxt = (ml < pt) ? pt : msg + 64'd1;
        end else if (hp < pt) begin
          nxt = pt;
        end else if (pt <= ml) begin
          nxt = ((hlc_now < msg) ? msg : hlc_now) + 64'd1;
        end else begin
          nxt = hlc_now + 64'd1;
        end
        hlc_now   = nxt;
        res.stamp = nxt;
      end
    end
    return res;
  endfunction

  // Offers one word on the slave side and records its expected result once it is taken.
  task automatic put_word(input hlc_op_e op, input logic [59:0] nsec, input logic [63:0] msg,
                          input logic typed, input stamp_result_t want);
    stamp_result_t predicted;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, msg, nsec};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_clock(op, nsec, msg);
    pending_stamps_q.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    while (pending_stamps_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_epsilon(input logic [63:0] value);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    epsilon_now = (value + LogicMask) & PhysMask;
  endtask

  // Mostly a slowly advancing local time with messages a few clock steps either side
  // of it or of the current stamp, so every branch of the merge is reached; the rest is noise.
  task automatic run_phase(input int unsigned words);
    logic [59:0] now_ns;
    logic [63:0] pt_guess;
    logic [63:0] base;
    logic [63:0] msg;
    hlc_op_e     op;
    int unsigned roll;
    now_ns = ($urandom_range(0, 3) == 0) ? NsecMax - 60'($urandom_range(0, 100000))
                                         : 60'({$urandom, $urandom});
    for (int unsigned i = 0; i < words; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        op = hlc_op_e'($urandom_range(0, 1));
        put_word(op, 60'({$urandom, $urandom}), {$urandom, $urandom}, 1'b0, '0);
      end else begin
        if ($urandom_range(0, 3) != 0) now_ns = now_ns + 60'($urandom_range(1, 40000));
        op       = ($urandom_range(0, 99) < 60) ? OP_RECEIVE : OP_LOCAL;
        pt_guess = ({4'b0, now_ns} << UnitsShift) & PhysMask;
        base     = $urandom_range(0, 1) ? pt_guess : hlc_now;
        if (roll < 20) begin
          msg = pt_guess + ({$urandom, $urandom} >> $urandom_range(20, 40));
        end else begin
          msg = base + (64'($urandom_range(0, 8)) << LogicalBitsDef)
              - (64'd4 << LogicalBitsDef) + (64'($urandom) & LogicMask);
        end
        put_word(op, now_ns, msg, 1'b0, '0);
      end
    end
  endtask

  // Master side: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk_i) begin
    stamp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_stamps_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected word: stamp %h lead %h sync_error %b",
                   m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser);
        end
      end else begin
        want = pending_stamps_q.pop_front();
        if (m_axis_tdata[63:0] !== want.stamp || m_axis_tdata[127:64] !== want.lead ||
            m_axis_tuser !== want.sync_err) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: stamp %h/%h lead %h/%h sync_error %b/%b (expected/actual)",
                     want.stamp, m_axis_tdata[63:0], want.lead, m_axis_tdata[127:64],
                     want.sync_err, m_axis_tuser);
          end
        end
      end
    end
    m_axis_tready <= (snk_idle_pct == 0) || ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("hybrid_logical_clock_top_test: errors");
      $finish;
    end
  end

  initial begin
    hlc_now     = '0;
    epsilon_now = EpsilonReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < NumRows; r++) begin
      if (DirRows[r].is_cfg) begin
        write_epsilon(DirRows[r].arg);
      end else begin
        put_word(DirRows[r].op, DirRows[r].nsec, DirRows[r].arg, DirRows[r].typed,
                 '{DirRows[r].w_stamp, DirRows[r].w_lead, DirRows[r].w_err});
      end
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0:       write_epsilon({$urandom, $urandom});
        1:       write_epsilon(64'd0);
        2:       write_epsilon(EpsilonReset);
        3:       write_epsilon(AllOnes);
        4:       write_epsilon(TopPhys);
        5:       write_epsilon({28'd0, $urandom, 4'($urandom)});
        6:       write_epsilon(64'd1);
        default: write_epsilon({$urandom, $urandom});
      endcase
      // One phase runs with both sides streaming at full rate.
      src_idle_pct = (p == 5) ? 0 : 16;
      snk_idle_pct = (p == 5) ? 0 : 16;
      run_phase(PhaseWords);
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("hybrid_logical_clock_top_test: clean");
    end else begin
      $display("hybrid_logical_clock_top_test: errors");
    end
    $finish;
  end

endmodule
